>>> rtl/pwm_pkg.sv
// Package for the permutation weight matrix: request and response structs,
// command and status codes and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pwm_pkg;

  localparam int RND_W = 16;
  localparam int AMT_W = 16;
  localparam int SUM_W = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [1:0] CMD_FILL  = 2'd0;
  localparam logic [1:0] CMD_SCALE = 2'd1;
  localparam logic [1:0] CMD_ADD   = 2'd2;
  localparam logic [1:0] CMD_DRAW  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DEAD  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [AMT_W-1:0] amount;
    logic [3:0]       row_index;
    logic [3:0]       column_index;
    logic             final_row;
    logic [RND_W-1:0] random_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       drawn_row;
    logic [3:0]       drawn_column;
    logic             draw_done;
    logic [SUM_W-1:0] line_sum;
  } out_rsp_t;

endpackage
`default_nettype wire

>>> rtl/pwm_ram.sv
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pwm_ram #(
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/pwm_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pwm_mod #(
  parameter int DVD_W = 16,
  parameter int DIV_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] rem
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  shift_r, shift_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W:0]    trial;

  assign trial = {rem_r, shift_r[DVD_W-1]};

  // one shift and conditional subtract per cycle
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    if (start) begin
      busy_nxt  = 1'b1;
      step_nxt  = STEP_W'(DVD_W);
      shift_nxt = dividend;
      div_nxt   = divisor;
      rem_nxt   = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      shift_nxt = shift_r << 1;
      step_nxt  = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    shift_r <= shift_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

>>> rtl/permutation_weight_matrix.sv
// Top level of the permutation weight matrix: command sequencer around the
// count memory and the row mark memory. Depends on pwm_pkg, pwm_ram, pwm_mod.
//
// Usage: one request on in_valid/in_ready/in_req gives exactly one response
// on out_valid/out_ready/out_rsp. Requests are handled one at a time; the
// next request is taken as soon as the sequencer is idle, even while the
// previous response still waits in the output register.
// Work per request, from acceptance to response loaded:
//   add entry:          read the entry and its row marks, then write both
//   scale by one:       no memory access
//   fill, scale by 0:   one sweep, one memory write per cycle
//   scale:              one sweep (read, then multiply and write back)
//   draw row:           a column count pass and a pick
//                       pass over the row marks, one column per cycle, and
//                       a wait on the remainder unit in between
// The memory port is the limit for the sweeps, the column scans and the
// remainder unit for a draw.
// Reset: a clearing pass over every entry zeroes both memories; no request
// is taken during it. If the receiver stalls, the sequencer finishes its
// current request and holds the response until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module permutation_weight_matrix #(
  parameter int DIM        = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pwm_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pwm_pkg::out_rsp_t      out_rsp
);

  localparam int IDX_W = $clog2(DIM);
  localparam int CW    = $clog2(DIM + 1);
  localparam int AW    = 2 * IDX_W;
  localparam int EXT_W = ((COUNT_BITS > pwm_pkg::AMT_W) ? COUNT_BITS : pwm_pkg::AMT_W) + 1;
  localparam int FP_W  = ((COUNT_BITS + IDX_W + 1) > (pwm_pkg::SUM_W + 1)) ?
                         (COUNT_BITS + IDX_W + 1) : (pwm_pkg::SUM_W + 1);
  localparam int SP_W  = pwm_pkg::SUM_W + pwm_pkg::AMT_W;
  localparam int MP_W  = COUNT_BITS + pwm_pkg::AMT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(DIM - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FILL   = 4'd1;
  localparam logic [3:0] S_SC_RD  = 4'd2;
  localparam logic [3:0] S_SC_WR  = 4'd3;
  localparam logic [3:0] S_ADD_RD = 4'd4;
  localparam logic [3:0] S_ADD_WR = 4'd5;
  localparam logic [3:0] S_DR_RD  = 4'd6;
  localparam logic [3:0] S_DR_LAT = 4'd7;
  localparam logic [3:0] S_DR_CNT = 4'd8;
  localparam logic [3:0] S_DR_MOD = 4'd9;
  localparam logic [3:0] S_DR_SEL = 4'd10;
  localparam logic [3:0] S_DR_UPD = 4'd11;
  localparam logic [3:0] S_RESP   = 4'd12;

  logic [3:0]                  state_r, state_nxt;
  pwm_pkg::in_req_t            req_r, req_nxt;
  logic [IDX_W-1:0]            sw_row_r, sw_row_nxt;
  logic [IDX_W-1:0]            sw_col_r, sw_col_nxt;
  logic [COUNT_BITS-1:0]       fill_val_r, fill_val_nxt;
  logic                        emit_r, emit_nxt;
  logic                        sat_r, sat_nxt;
  logic [pwm_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [IDX_W-1:0]            draw_row_r, draw_row_nxt;
  logic [DIM-1:0]              unpicked_r, unpicked_nxt;
  logic [DIM-1:0]              avail_r, avail_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               skip_r, skip_nxt;
  logic [IDX_W-1:0]            scan_col_r, scan_col_nxt;
  logic [IDX_W-1:0]            sel_r, sel_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic [3:0]                  drow_r, drow_nxt;
  logic [3:0]                  dcol_r, dcol_nxt;
  logic                        done_r, done_nxt;
  logic                        out_valid_r, out_valid_nxt;
  pwm_pkg::out_rsp_t           out_rsp_r, out_rsp_nxt;

  // memory ports
  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic                  mark_we;
  logic [IDX_W-1:0]      mark_waddr, mark_raddr;
  logic [DIM-1:0]        mark_wdata, mark_rdata;

  // remainder unit
  logic          mod_start, mod_done;
  logic [CW-1:0] mod_rem;

  // datapath helpers
  logic                   fill_sat;
  logic [COUNT_BITS-1:0]  fill_clip;
  logic [FP_W-1:0]        fill_prod;
  logic [SP_W-1:0]        scale_sum;
  logic [MP_W-1:0]        scale_prod;
  logic [EXT_W-1:0]       add_val;
  logic [pwm_pkg::SUM_W:0] add_sum;
  logic                   add_in_range;
  logic [IDX_W-1:0]       req_row, req_col;
  logic                   sw_col_last, sw_last;
  logic [CW-1:0]          cnt_inc;
  logic [COUNT_BITS-1:0]  dec_val;
  logic [DIM-1:0]         sel_hot, req_col_hot;

  pwm_ram #(.WIDTH(COUNT_BITS), .ADDR_W(AW)) u_count_mem (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pwm_ram #(.WIDTH(DIM), .ADDR_W(IDX_W)) u_mark_mem (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  pwm_mod #(.DVD_W(pwm_pkg::RND_W), .DIV_W(CW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (req_r.random_value),
    .divisor  (cnt_inc),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // fill value and sum clipping
  assign fill_sat  = EXT_W'(in_req.amount) > EXT_W'(CNT_MAX);
  assign fill_clip = fill_sat ? CNT_MAX : COUNT_BITS'(in_req.amount);
  assign fill_prod = FP_W'(fill_clip) * FP_W'(DIM);
  assign scale_sum = SP_W'(sum_r) * SP_W'(in_req.amount);

  // read-modify-write arithmetic
  assign scale_prod   = MP_W'(cnt_rdata) * MP_W'(req_r.amount);
  assign add_val      = EXT_W'(cnt_rdata) + EXT_W'(req_r.amount);
  assign add_sum      = (pwm_pkg::SUM_W + 1)'(sum_r) + (pwm_pkg::SUM_W + 1)'(req_r.amount);
  assign add_in_range = (32'(req_r.row_index) < DIM) && (32'(req_r.column_index) < DIM);
  assign req_row      = IDX_W'(req_r.row_index);
  assign req_col      = IDX_W'(req_r.column_index);
  assign req_col_hot  = DIM'(1) << req_col;
  assign sel_hot      = DIM'(1) << sel_r;
  assign dec_val      = (cnt_rdata != '0) ? (cnt_rdata - 1'b1) : cnt_rdata;
  assign cnt_inc      = cnt_r + CW'(avail_r[scan_col_r]);

  assign sw_col_last = (sw_col_r == LAST_IDX);
  assign sw_last     = sw_col_last && (sw_row_r == LAST_IDX);

  // read addresses
  always_comb begin
    if (state_r == S_SC_RD) begin
      cnt_raddr = {sw_row_r, sw_col_r};
    end else if (state_r == S_ADD_RD) begin
      cnt_raddr = {req_row, req_col};
    end else begin
      cnt_raddr = {draw_row_r, scan_col_r};
    end
    mark_raddr = (state_r == S_ADD_RD) ? req_row : draw_row_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    sw_row_nxt    = sw_row_r;
    sw_col_nxt    = sw_col_r;
    fill_val_nxt  = fill_val_r;
    emit_nxt      = emit_r;
    sat_nxt       = sat_r;
    sum_nxt       = sum_r;
    draw_row_nxt  = draw_row_r;
    unpicked_nxt  = unpicked_r;
    avail_nxt     = avail_r;
    cnt_nxt       = cnt_r;
    skip_nxt      = skip_r;
    scan_col_nxt  = scan_col_r;
    sel_nxt       = sel_r;
    status_nxt    = status_r;
    drow_nxt      = drow_r;
    dcol_nxt      = dcol_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    cnt_we        = 1'b0;
    cnt_waddr     = {sw_row_r, sw_col_r};
    cnt_wdata     = fill_val_r;
    mark_we       = 1'b0;
    mark_waddr    = sw_row_r;
    mark_wdata    = '0;
    mod_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req;
          sat_nxt    = 1'b0;
          status_nxt = pwm_pkg::ST_OK;
          drow_nxt   = '0;
          dcol_nxt   = '0;
          done_nxt   = 1'b0;
          sw_row_nxt = '0;
          sw_col_nxt = '0;
          emit_nxt   = 1'b1;
          // any non-draw command abandons a draw in progress
          if (in_req.cmd != pwm_pkg::CMD_DRAW) begin
            draw_row_nxt = '0;
            unpicked_nxt = '1;
          end
          unique case (in_req.cmd)
            pwm_pkg::CMD_FILL: begin
              fill_val_nxt = fill_clip;
              if (fill_prod > FP_W'(pwm_pkg::SUM_MAX)) begin
                sum_nxt = pwm_pkg::SUM_MAX;
                sat_nxt = 1'b1;
              end else begin
                sum_nxt = pwm_pkg::SUM_W'(fill_prod);
                sat_nxt = fill_sat;
              end
              state_nxt = S_FILL;
            end
            pwm_pkg::CMD_SCALE: begin
              if (in_req.amount == '0) begin
                fill_val_nxt = '0;
                sum_nxt      = '0;
                state_nxt    = S_FILL;
              end else if (in_req.amount == pwm_pkg::AMT_W'(1)) begin
                state_nxt = S_RESP;
              end else begin
                if (scale_sum > SP_W'(pwm_pkg::SUM_MAX)) begin
                  sum_nxt = pwm_pkg::SUM_MAX;
                  sat_nxt = 1'b1;
                end else begin
                  sum_nxt = pwm_pkg::SUM_W'(scale_sum);
                end
                state_nxt = S_SC_RD;
              end
            end
            pwm_pkg::CMD_ADD: begin
              state_nxt = S_ADD_RD;
            end
            pwm_pkg::CMD_DRAW: begin
              drow_nxt = 4'(draw_row_r);
              if (sum_r == '0) begin
                status_nxt = pwm_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_DR_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // sweep writing one entry per cycle, a row of marks on column zero
      S_FILL: begin
        cnt_we = 1'b1;
        if (sw_col_r == '0) begin
          mark_we    = 1'b1;
          mark_wdata = (fill_val_r != '0) ? '1 : '0;
        end
        sw_col_nxt = sw_col_last ? '0 : sw_col_r + 1'b1;
        if (sw_col_last) begin
          sw_row_nxt = sw_row_r + 1'b1;
        end
        if (sw_last) begin
          state_nxt = emit_r ? S_RESP : S_IDLE;
        end
      end

      S_SC_RD: begin
        state_nxt = S_SC_WR;
      end

      // multiply, clip and write back the entry read last cycle
      S_SC_WR: begin
        cnt_we = 1'b1;
        if (scale_prod > MP_W'(CNT_MAX)) begin
          cnt_wdata = CNT_MAX;
          sat_nxt   = 1'b1;
        end else begin
          cnt_wdata = COUNT_BITS'(scale_prod);
        end
        sw_col_nxt = sw_col_last ? '0 : sw_col_r + 1'b1;
        if (sw_col_last) begin
          sw_row_nxt = sw_row_r + 1'b1;
        end
        state_nxt = sw_last ? S_RESP : S_SC_RD;
      end

      S_ADD_RD: begin
        state_nxt = S_ADD_WR;
      end

      // add weight to one entry and mark it, optionally commit the sum
      S_ADD_WR: begin
        if (add_in_range) begin
          cnt_we     = 1'b1;
          cnt_waddr  = {req_row, req_col};
          mark_we    = 1'b1;
          mark_waddr = req_row;
          mark_wdata = mark_rdata | req_col_hot;
          if (add_val > EXT_W'(CNT_MAX)) begin
            cnt_wdata = CNT_MAX;
            sat_nxt   = 1'b1;
          end else begin
            cnt_wdata = COUNT_BITS'(add_val);
          end
        end
        if (req_r.final_row) begin
          if (add_sum > (pwm_pkg::SUM_W + 1)'(pwm_pkg::SUM_MAX)) begin
            sum_nxt = pwm_pkg::SUM_MAX;
            sat_nxt = 1'b1;
          end else begin
            sum_nxt = pwm_pkg::SUM_W'(add_sum);
          end
        end
        state_nxt = S_RESP;
      end

      S_DR_RD: begin
        state_nxt = S_DR_LAT;
      end

      S_DR_LAT: begin
        avail_nxt    = mark_rdata & unpicked_r;
        cnt_nxt      = '0;
        scan_col_nxt = '0;
        state_nxt    = S_DR_CNT;
      end

      // count available columns one per cycle
      S_DR_CNT: begin
        cnt_nxt = cnt_inc;
        if (scan_col_r == LAST_IDX) begin
          if (cnt_inc == '0) begin
            status_nxt   = pwm_pkg::ST_DEAD;
            draw_row_nxt = '0;
            unpicked_nxt = '1;
            state_nxt    = S_RESP;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_DR_MOD;
          end
        end else begin
          scan_col_nxt = scan_col_r + 1'b1;
        end
      end

      S_DR_MOD: begin
        if (mod_done) begin
          skip_nxt     = mod_rem;
          scan_col_nxt = '0;
          state_nxt    = S_DR_SEL;
        end
      end

      // walk to the chosen available column; its count is read meanwhile
      S_DR_SEL: begin
        if (avail_r[scan_col_r]) begin
          if (skip_r == '0) begin
            sel_nxt   = scan_col_r;
            state_nxt = S_DR_UPD;
          end else begin
            skip_nxt = skip_r - 1'b1;
          end
        end
        if (!(avail_r[scan_col_r] && (skip_r == '0))) begin
          scan_col_nxt = scan_col_r + 1'b1;
        end
      end

      // decrement the picked entry and update its mark
      S_DR_UPD: begin
        cnt_we     = 1'b1;
        cnt_waddr  = {draw_row_r, sel_r};
        cnt_wdata  = dec_val;
        mark_we    = 1'b1;
        mark_waddr = draw_row_r;
        mark_wdata = (mark_rdata & ~sel_hot) | ((dec_val != '0) ? sel_hot : '0);
        dcol_nxt   = 4'(sel_r);
        if (draw_row_r == LAST_IDX) begin
          done_nxt     = 1'b1;
          sum_nxt      = sum_r - 1'b1;
          draw_row_nxt = '0;
          unpicked_nxt = '1;
        end else begin
          draw_row_nxt = draw_row_r + 1'b1;
          unpicked_nxt = unpicked_r & ~sel_hot;
        end
        state_nxt = S_RESP;
      end

      // load the response once the output register is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_rsp_nxt.status       = (status_r == pwm_pkg::ST_OK && sat_r) ?
                                     pwm_pkg::ST_SAT : status_r;
          out_rsp_nxt.drawn_row    = drow_r;
          out_rsp_nxt.drawn_column = dcol_r;
          out_rsp_nxt.draw_done    = done_r;
          out_rsp_nxt.line_sum     = sum_r;
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // registers; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      sw_row_r    <= '0;
      sw_col_r    <= '0;
      fill_val_r  <= '0;
      emit_r      <= 1'b0;
      sat_r       <= 1'b0;
      sum_r       <= '0;
      draw_row_r  <= '0;
      unpicked_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_row_r    <= sw_row_nxt;
      sw_col_r    <= sw_col_nxt;
      fill_val_r  <= fill_val_nxt;
      emit_r      <= emit_nxt;
      sat_r       <= sat_nxt;
      sum_r       <= sum_nxt;
      draw_row_r  <= draw_row_nxt;
      unpicked_r  <= unpicked_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    avail_r    <= avail_nxt;
    cnt_r      <= cnt_nxt;
    skip_r     <= skip_nxt;
    scan_col_r <= scan_col_nxt;
    sel_r      <= sel_nxt;
    status_r   <= status_nxt;
    drow_r     <= drow_nxt;
    dcol_r     <= dcol_nxt;
    done_r     <= done_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // one column picked per drawn row
  a_picked_rows: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(unpicked_r) == (DIM - int'(draw_row_r)))
    else $error("picked columns disagree with draw row");

  // remainder must select an existing available column
  a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DR_SEL) |-> (skip_r < cnt_r))
    else $error("pick index beyond available count");

  // an empty response only with a zero sum
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && status_r == pwm_pkg::ST_EMPTY) |-> (sum_r == '0))
    else $error("empty status with nonzero sum");

  // finishing the last row restarts the draw
  a_draw_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DR_UPD && draw_row_r == LAST_IDX) |=>
    (draw_row_r == '0 && unpicked_r == '1))
    else $error("draw not restarted after last row");

endmodule
`default_nettype wire

>>> dv/tb_permutation_weight_matrix.sv
// Testbench for the permutation weight matrix: directed and random requests
// checked against a cycle-free model of the count matrix. Depends on pwm_pkg.
`timescale 1ns / 1ps
module tb_permutation_weight_matrix;

  localparam int N     = 16;
  localparam int CMAX  = 65535;
  localparam int REQ_W = $bits(pwm_pkg::in_req_t);

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pwm_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pwm_pkg::out_rsp_t out_rsp;

  // model state
  int unsigned cnt_m [N*N];
  bit          pos_m [N*N];
  int unsigned sum_m;
  int unsigned row_m;
  bit [N-1:0]  free_m;

  pwm_pkg::out_rsp_t expected_rsp_q [$];
  int       err_cnt = 0;
  int       idle_pct = 28;

  permutation_weight_matrix u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req(in_req), .out_valid(out_valid), .out_ready(out_ready),
    .out_rsp(out_rsp)
  );

  always #10 clk = ~clk;

  // abandon a draw in progress
  function automatic void drop_draw();
    row_m  = 0;
    free_m = '1;
  endfunction

  function automatic bit fill_matrix(int unsigned v);
    bit sat;
    sat = 0;
    for (int i = 0; i < N*N; i++) begin
      cnt_m[i] = v;
      pos_m[i] = (v != 0);
    end
    sum_m = v * N;
    if (sum_m > pwm_pkg::SUM_MAX) begin
      sum_m = pwm_pkg::SUM_MAX;
      sat   = 1;
    end
    return sat;
  endfunction

  // compute the response and update the matrix for one request
  function automatic pwm_pkg::out_rsp_t predict_matrix_step(pwm_pkg::in_req_t r);
    pwm_pkg::out_rsp_t o;
    longint unsigned p;
    int unsigned k, avail_n, skip;
    bit [N-1:0]  avail;
    o = '0;
    case (r.cmd)
      pwm_pkg::CMD_FILL: begin
        drop_draw();
        if (fill_matrix(r.amount)) o.status = pwm_pkg::ST_SAT;
      end
      pwm_pkg::CMD_SCALE: begin
        drop_draw();
        if (r.amount == 0) begin
          if (fill_matrix(0)) o.status = pwm_pkg::ST_SAT;
        end else if (r.amount != 1) begin
          for (int i = 0; i < N*N; i++) begin
            p = longint'(cnt_m[i]) * r.amount;
            if (p > CMAX) begin
              p = CMAX;
              o.status = pwm_pkg::ST_SAT;
            end
            cnt_m[i] = p;
          end
          p = longint'(sum_m) * r.amount;
          if (p > pwm_pkg::SUM_MAX) begin
            p = pwm_pkg::SUM_MAX;
            o.status = pwm_pkg::ST_SAT;
          end
          sum_m = p;
        end
      end
      pwm_pkg::CMD_ADD: begin
        drop_draw();
        k = r.row_index * N + r.column_index;
        cnt_m[k] += r.amount;
        if (cnt_m[k] > CMAX) begin
          cnt_m[k] = CMAX;
          o.status = pwm_pkg::ST_SAT;
        end
        pos_m[k] = 1;
        if (r.final_row) begin
          sum_m += r.amount;
          if (sum_m > pwm_pkg::SUM_MAX) begin
            sum_m = pwm_pkg::SUM_MAX;
            o.status = pwm_pkg::ST_SAT;
          end
        end
      end
      default: begin
        o.drawn_row = row_m;
        if (sum_m == 0) begin
          o.status = pwm_pkg::ST_EMPTY;
        end else begin
          avail   = '0;
          avail_n = 0;
          for (int c = 0; c < N; c++) begin
            if (pos_m[row_m*N + c] && free_m[c]) begin
              avail[c] = 1;
              avail_n++;
            end
          end
          if (avail_n == 0) begin
            o.status = pwm_pkg::ST_DEAD;
            drop_draw();
          end else begin
            skip = r.random_value % avail_n;
            for (int c = 0; c < N; c++) begin
              if (avail[c]) begin
                if (skip == 0) begin
                  o.drawn_column = c;
                  break;
                end
                skip--;
              end
            end
            k = row_m * N + o.drawn_column;
            if (cnt_m[k] != 0) cnt_m[k]--;
            pos_m[k] = (cnt_m[k] != 0);
            free_m[o.drawn_column] = 0;
            if (row_m == N - 1) begin
              o.draw_done = 1;
              sum_m--;
              drop_draw();
            end else begin
              row_m++;
            end
          end
        end
      end
    endcase
    o.line_sum = sum_m;
    return o;
  endfunction

  // send one request and queue its expected response
  task automatic send_req(pwm_pkg::in_req_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rsp_q.push_back(predict_matrix_step(r));
  endtask

  function automatic pwm_pkg::in_req_t mk(logic [1:0] cmd, int amt, int r = 0, int c = 0,
                                          bit fin = 0, int rnd = 0);
    pwm_pkg::in_req_t q;
    q.cmd = cmd;
    q.amount = amt;
    q.row_index = r;
    q.column_index = c;
    q.final_row = fin;
    q.random_value = rnd;
    return q;
  endfunction

  // full permutation, weighted
  task automatic add_perm(int w);
    int perm [N];
    int j, t;
    for (int i = 0; i < N; i++) perm[i] = i;
    for (int i = N - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < N; i++) begin
      send_req(mk(pwm_pkg::CMD_ADD, w, i, perm[i], i == N - 1));
    end
  endtask

  task automatic draw_rows(int n);
    for (int i = 0; i < n; i++) send_req(mk(pwm_pkg::CMD_DRAW, 0, 0, 0, 0, $urandom));
  endtask

  // response check
  always @(posedge clk) begin
    pwm_pkg::out_rsp_t e;
    if (rst_n) out_ready <= ($urandom_range(99) >= idle_pct);
    if (out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $error("response with none expected");
        err_cnt++;
      end else begin
        e = expected_rsp_q.pop_front();
        if (out_rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_rsp.status); err_cnt++;
        end
        if (out_rsp.drawn_row !== e.drawn_row) begin
          $error("drawn_row exp %0d got %0d", e.drawn_row, out_rsp.drawn_row);
          err_cnt++;
        end
        if (out_rsp.drawn_column !== e.drawn_column) begin
          $error("drawn_column exp %0d got %0d", e.drawn_column, out_rsp.drawn_column);
          err_cnt++;
        end
        if (out_rsp.draw_done !== e.draw_done) begin
          $error("draw_done exp %0d got %0d", e.draw_done, out_rsp.draw_done);
          err_cnt++;
        end
        if (out_rsp.line_sum !== e.line_sum) begin
          $error("line_sum exp %0d got %0d", e.line_sum, out_rsp.line_sum);
          err_cnt++;
        end
      end
    end
  end

  // empty draw, fill, scale edges, saturation
  task automatic test_directed();
    send_req(mk(pwm_pkg::CMD_DRAW, 0, 0, 0, 0, 16'hFFFF));
    send_req(mk(pwm_pkg::CMD_FILL, 16'hFFFF));
    send_req(mk(pwm_pkg::CMD_SCALE, 1));
    send_req(mk(pwm_pkg::CMD_SCALE, 2));
    send_req(mk(pwm_pkg::CMD_SCALE, 16'hFFFF));
    send_req(mk(pwm_pkg::CMD_SCALE, 0));
    send_req(mk(pwm_pkg::CMD_FILL, 1));
    draw_rows(3);
    send_req(mk(pwm_pkg::CMD_ADD, 0, 15, 15, 0));
    send_req(mk(pwm_pkg::CMD_ADD, 16'hFFFF, 3, 4, 1));
    send_req(mk(pwm_pkg::CMD_FILL, 0));
    send_req(mk(pwm_pkg::CMD_ADD, 0, 0, 0, 1));
    send_req(mk(pwm_pkg::CMD_ADD, 5, 0, 0, 1));
    send_req(mk(pwm_pkg::CMD_DRAW, 0, 0, 0, 0, 0));
    send_req(mk(pwm_pkg::CMD_DRAW, 0, 0, 0, 0, 0));
  endtask

  // drawn permutations from sums of random permutations
  task automatic test_decompose(int rounds);
    for (int k = 0; k < rounds; k++) begin
      send_req(mk(pwm_pkg::CMD_FILL, 0));
      for (int p = 0; p < 3; p++) add_perm($urandom_range(2));
      draw_rows($urandom_range(N + 4, 3 * N));
    end
  endtask

  // random noise requests
  task automatic test_noise(int n);
    pwm_pkg::in_req_t r;
    for (int i = 0; i < n; i++) begin
      r = pwm_pkg::in_req_t'(REQ_W'({$urandom, $urandom}));
      if (r.cmd == pwm_pkg::CMD_FILL) r.amount = $urandom_range(4);
      if (r.cmd == pwm_pkg::CMD_SCALE && ($urandom_range(3) != 0)) begin
        r.amount = $urandom_range(3);
      end
      send_req(r);
    end
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_decompose(6);
    idle_pct = 0;
    test_decompose(2);
    idle_pct = 28;
    test_noise(60);
    test_decompose(2);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_rsp_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> permutation_weight_matrix.f
rtl/pwm_pkg.sv
rtl/pwm_ram.sv
rtl/pwm_mod.sv
rtl/permutation_weight_matrix.sv
dv/tb_permutation_weight_matrix.sv
